// ----- hw/rtl/tvts_pkg.sv -----
package tvts_pkg;

    // default geometry
    localparam int TILE_DIM_DEF  = 8;
    localparam int MAX_TILES_DEF = 4;

    // fixed field widths
    localparam int CFG_W     = 3;
    localparam int CFG_IDX_W = 2;
    localparam int WCOORD_W  = 5;
    localparam int VOXEL_W   = 16;
    localparam int SCOORD_W  = 17;
    localparam int FRAC_W    = 8;
    localparam int RESULT_W  = 24;

    // signed voxel coordinate: 9-bit floor plus one for the upper neighbor
    localparam int COORD_W = 10;

    // blend arithmetic
    localparam int WAXIS_W  = 9;   // 0..256
    localparam int WPAIR_W  = 17;  // 0..65536
    localparam int WEIGHT_W = 25;  // 0..2^24
    localparam int ACC_W    = 40;
    localparam logic [WAXIS_W-1:0] UNIT_WEIGHT = 9'd256;

    localparam logic [2:0] CORNER_LAST = 3'd7;

    // action codes of an input word
    localparam logic ACT_WRITE  = 1'b0;
    localparam logic ACT_SAMPLE = 1'b1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TILES_WIDE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TILES_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TILES_DEEP = 2'd2;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ISSUE,
        ST_DRAIN
    } state_t;

    typedef struct packed {
        logic [CFG_W-1:0] tiles_wide;
        logic [CFG_W-1:0] tiles_high;
        logic [CFG_W-1:0] tiles_deep;
    } cfg_t;

    typedef struct packed {
        logic               valid;
        logic               is_write;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] z;
    } addr_req_t;

    typedef struct packed {
        logic valid;     // address ready this cycle
        logic is_write;
        logic hit;       // voxel lies inside the tiles in use
        logic pending;   // a request sits in the first stage
    } addr_rsp_t;

    function automatic int addr_w(int tile_dim, int max_tiles);
        return $clog2((tile_dim * max_tiles) ** 3);
    endfunction

endpackage

// ----- hw/rtl/tvts_addr.sv -----
module tvts_addr #(
    parameter int TILE_DIM           = tvts_pkg::TILE_DIM_DEF,
    parameter int MAX_TILES_PER_AXIS = tvts_pkg::MAX_TILES_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  tvts_pkg::cfg_t        cfg,
    input  tvts_pkg::addr_req_t   req,
    output tvts_pkg::addr_rsp_t   rsp,
    output logic [tvts_pkg::addr_w(TILE_DIM, MAX_TILES_PER_AXIS)-1:0] addr
);
    import tvts_pkg::*;

    localparam int AXIS_SPAN   = TILE_DIM * MAX_TILES_PER_AXIS;
    localparam int TILE_WORDS  = TILE_DIM * TILE_DIM * TILE_DIM;
    localparam int STORE_DEPTH = AXIS_SPAN * AXIS_SPAN * AXIS_SPAN;
    localparam int ADDR_W      = addr_w(TILE_DIM, MAX_TILES_PER_AXIS);
    localparam int SPAN_BITS   = $clog2(AXIS_SPAN + 1);
    localparam int CMP_W       = (SPAN_BITS > COORD_W - 1) ? SPAN_BITS : COORD_W - 1;
    localparam int TIDX_W      = (MAX_TILES_PER_AXIS > 1) ? $clog2(MAX_TILES_PER_AXIS) : 1;
    localparam int LOC_W       = $clog2(TILE_DIM);
    localparam int CNT_W       = $clog2(MAX_TILES_PER_AXIS + 1);

    function automatic logic [CNT_W-1:0] clamp(logic [CFG_W-1:0] n);
        logic [CNT_W-1:0] c;
        if (int'(n) > MAX_TILES_PER_AXIS)
            c = CNT_W'(MAX_TILES_PER_AXIS);
        else
            c = CNT_W'(n);
        return c;
    endfunction

    function automatic logic [CMP_W-1:0] mag(logic [COORD_W-1:0] c);
        return CMP_W'(c[COORD_W-2:0]);
    endfunction

    function automatic logic axis_hit(logic [COORD_W-1:0] c, logic [CNT_W-1:0] n);
        return !c[COORD_W-1] && (mag(c) < CMP_W'(n) * CMP_W'(TILE_DIM));
    endfunction

    // tile index by threshold compare; beyond the last tile is caught by axis_hit
    function automatic logic [TIDX_W-1:0] axis_tile(logic [COORD_W-1:0] c);
        logic [TIDX_W-1:0] t;
        t = '0;
        for (int k = 1; k < MAX_TILES_PER_AXIS; k++) begin
            if (mag(c) >= CMP_W'(k * TILE_DIM))
                t = TIDX_W'(k);
        end
        return t;
    endfunction

    function automatic logic [LOC_W-1:0] axis_local(logic [COORD_W-1:0] c,
                                                    logic [TIDX_W-1:0] t);
        logic [CMP_W-1:0] r;
        r = mag(c) - CMP_W'(t) * CMP_W'(TILE_DIM);
        return r[LOC_W-1:0];
    endfunction

    logic [CNT_W-1:0] cnt_w, cnt_h, cnt_d;

    // stage A: split each axis into tile and offset
    logic              valid_a_reg, is_write_a_reg, hit_a_reg;
    logic [TIDX_W-1:0] tx_a_reg, ty_a_reg, tz_a_reg;
    logic [LOC_W-1:0]  lx_a_reg, ly_a_reg, lz_a_reg;

    // stage B: linear address
    logic              valid_b_reg, is_write_b_reg, hit_b_reg;
    logic [ADDR_W-1:0] addr_b_reg;
    logic [ADDR_W-1:0] tile_lin, local_lin, addr_next;
    logic [TIDX_W-1:0] tx, ty, tz;

    assign cnt_w = clamp(cfg.tiles_wide);
    assign cnt_h = clamp(cfg.tiles_high);
    assign cnt_d = clamp(cfg.tiles_deep);

    assign tx = axis_tile(req.x);
    assign ty = axis_tile(req.y);
    assign tz = axis_tile(req.z);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_a_reg <= 1'b0;
            valid_b_reg <= 1'b0;
        end else begin
            valid_a_reg <= req.valid;
            valid_b_reg <= valid_a_reg;
        end
        is_write_a_reg <= req.is_write;
        hit_a_reg      <= axis_hit(req.x, cnt_w) && axis_hit(req.y, cnt_h)
                          && axis_hit(req.z, cnt_d);
        tx_a_reg       <= tx;
        ty_a_reg       <= ty;
        tz_a_reg       <= tz;
        lx_a_reg       <= axis_local(req.x, tx);
        ly_a_reg       <= axis_local(req.y, ty);
        lz_a_reg       <= axis_local(req.z, tz);
        is_write_b_reg <= is_write_a_reg;
        hit_b_reg      <= hit_a_reg;
        addr_b_reg     <= addr_next;
    end

    always_comb begin
        tile_lin  = (ADDR_W'(tz_a_reg) * ADDR_W'(cnt_h) + ADDR_W'(ty_a_reg)) * ADDR_W'(cnt_w)
                    + ADDR_W'(tx_a_reg);
        local_lin = ADDR_W'(lz_a_reg) * ADDR_W'(TILE_DIM * TILE_DIM)
                    + ADDR_W'(ly_a_reg) * ADDR_W'(TILE_DIM) + ADDR_W'(lx_a_reg);
        addr_next = tile_lin * ADDR_W'(TILE_WORDS) + local_lin;
    end

    assign rsp.valid    = valid_b_reg;
    assign rsp.is_write = is_write_b_reg;
    assign rsp.hit      = hit_b_reg;
    assign rsp.pending  = valid_a_reg;
    assign addr         = addr_b_reg;

    a_req_to_rsp: assert property (@(posedge aclk) disable iff (!aresetn)
        req.valid |-> ##2 rsp.valid)
        else $error("address request lost in pipeline");

    a_hit_in_store: assert property (@(posedge aclk) disable iff (!aresetn)
        (rsp.valid && rsp.hit) |-> (longint'(addr) < longint'(STORE_DEPTH)))
        else $error("hit address beyond voxel store");

    a_hit_needs_tiles: assert property (@(posedge aclk) disable iff (!aresetn)
        (rsp.valid && rsp.hit) |-> (cfg.tiles_wide != '0 && cfg.tiles_high != '0
                                    && cfg.tiles_deep != '0))
        else $error("hit with an empty tile range");

endmodule

// ----- hw/rtl/tiled_volume_trilinear_sampler.sv -----
// Trilinear sampler over a tiled volume of 16-bit voxels. An input word with
// action 0 stores write_value at voxel (write_x, write_y, write_z); action 1
// samples at the signed fixed-point position (sample_x, sample_y, sample_z),
// 8 fraction bits, and returns one result word with the trilinear blend of
// the eight neighbors, 8 fraction bits, truncated. Neighbors that are negative
// or fall in a tile beyond tiles_wide/high/deep read as 0; writes there are
// dropped. The block handles one word at a time: the next word is taken only
// once the previous one has drained from the pipeline and, for a sample, its
// result is loaded into the output register. The sample time is set by the
// eight corner reads, issued one per cycle through the single read port of the
// voxel memory, plus the depth of the address, read, multiply and accumulate
// pipeline. A finished result waits in the output register; the block still
// returns to idle and takes the next word, and only the following sample
// stalls while it waits. After reset the voxel memory is cleared one entry
// per cycle, all (TILE_DIM * MAX_TILES_PER_AXIS)^3 entries (32768 at the
// defaults), with s_ready low; configuration writes are taken at any time but
// belong in idle periods.
module tiled_volume_trilinear_sampler #(
    parameter int TILE_DIM           = tvts_pkg::TILE_DIM_DEF,
    parameter int MAX_TILES_PER_AXIS = tvts_pkg::MAX_TILES_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // configuration
    input  logic                                 cfg_wr_en,
    input  logic [tvts_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [tvts_pkg::CFG_W-1:0]           cfg_wdata,
    // input words
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic                                 s_action,
    input  logic [tvts_pkg::WCOORD_W-1:0]        s_write_x,
    input  logic [tvts_pkg::WCOORD_W-1:0]        s_write_y,
    input  logic [tvts_pkg::WCOORD_W-1:0]        s_write_z,
    input  logic [tvts_pkg::VOXEL_W-1:0]         s_write_value,
    input  logic signed [tvts_pkg::SCOORD_W-1:0] s_sample_x,
    input  logic signed [tvts_pkg::SCOORD_W-1:0] s_sample_y,
    input  logic signed [tvts_pkg::SCOORD_W-1:0] s_sample_z,
    // result words
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [tvts_pkg::RESULT_W-1:0]        m_sample_value
);
    import tvts_pkg::*;

    localparam int AXIS_SPAN   = TILE_DIM * MAX_TILES_PER_AXIS;
    localparam int STORE_DEPTH = AXIS_SPAN * AXIS_SPAN * AXIS_SPAN;
    localparam int ADDR_W      = addr_w(TILE_DIM, MAX_TILES_PER_AXIS);

    // configuration registers
    logic [CFG_W-1:0] tiles_wide_reg, tiles_high_reg, tiles_deep_reg;
    cfg_t             cfg;

    // sequencer
    state_t           state_reg, state_next;
    logic [ADDR_W-1:0] clr_addr_reg, clr_addr_next;
    logic [2:0]       cnt_reg, cnt_next;   // corner: bit0 x, bit1 y, bit2 z
    logic             issue, out_load, clr_we, pipe_empty;

    // accepted word
    logic                is_write_reg;
    logic [WCOORD_W-1:0] wr_x_reg, wr_y_reg, wr_z_reg;
    logic [VOXEL_W-1:0]  wr_value_reg;
    logic [COORD_W-1:0]  base_x_reg, base_y_reg, base_z_reg;
    logic [FRAC_W-1:0]   frac_x_reg, frac_y_reg, frac_z_reg;

    // address unit
    addr_req_t         req;
    addr_rsp_t         rsp;
    logic [ADDR_W-1:0] unit_addr;

    // weight pipeline, aligned with the address unit stages
    logic [WAXIS_W-1:0]  wx, wy, wz;
    logic [17:0]         wxy_full;
    logic [25:0]         w_full;
    logic [WPAIR_W-1:0]  wxy_a_reg;
    logic [WAXIS_W-1:0]  wz_a_reg;
    logic [WEIGHT_W-1:0] w_b_reg, w_r_reg;

    // voxel memory
    logic [VOXEL_W-1:0] mem [STORE_DEPTH];
    logic               mem_we, mem_re;
    logic [ADDR_W-1:0]  mem_waddr;
    logic [VOXEL_W-1:0] mem_wdata;
    logic [VOXEL_W-1:0] rd_data_reg;
    logic               rd_valid_reg, rd_hit_reg;

    // multiply and accumulate
    logic [VOXEL_W-1:0]  rd_voxel;
    logic [40:0]         prod_full;
    logic [ACC_W-1:0]    prod_reg, acc_reg;
    logic                prod_valid_reg;

    // output register
    logic                m_valid_reg;
    logic [RESULT_W-1:0] m_sample_value_reg;

    logic s_accept;

    assign s_accept = s_valid && s_ready;

    assign cfg.tiles_wide = tiles_wide_reg;
    assign cfg.tiles_high = tiles_high_reg;
    assign cfg.tiles_deep = tiles_deep_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tiles_wide_reg <= 3'd4;
            tiles_high_reg <= 3'd4;
            tiles_deep_reg <= 3'd4;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_TILES_WIDE: tiles_wide_reg <= cfg_wdata;
                REG_TILES_HIGH: tiles_high_reg <= cfg_wdata;
                REG_TILES_DEEP: tiles_deep_reg <= cfg_wdata;
                default: ;  // no register there
            endcase
        end
    end

    // pipeline holds nothing in flight
    assign pipe_empty = !rsp.pending && !rsp.valid && !rd_valid_reg && !prod_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
            cnt_reg      <= '0;
        end else begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            cnt_reg      <= cnt_next;
        end
    end

    always_comb begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        cnt_next      = cnt_reg;
        s_ready       = 1'b0;
        issue         = 1'b0;
        out_load      = 1'b0;
        clr_we        = 1'b0;
        unique case (state_reg)
            ST_CLEAR: begin
                clr_we        = 1'b1;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == ADDR_W'(STORE_DEPTH - 1))
                    state_next = ST_IDLE;
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cnt_next   = '0;
                    state_next = ST_ISSUE;
                end
            end
            ST_ISSUE: begin
                // one address per cycle: a single one for a write, eight corners for a sample
                issue    = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (is_write_reg || cnt_reg == CORNER_LAST)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN: begin
                if (pipe_empty) begin
                    if (is_write_reg) begin
                        state_next = ST_IDLE;
                    end else if (!m_valid_reg || m_ready) begin
                        out_load   = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end
        endcase
    end

    // capture the accepted word; floor is the sign-extended integer part
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            is_write_reg <= (s_action == ACT_WRITE);
            wr_x_reg     <= s_write_x;
            wr_y_reg     <= s_write_y;
            wr_z_reg     <= s_write_z;
            wr_value_reg <= s_write_value;
            base_x_reg   <= {s_sample_x[SCOORD_W-1], s_sample_x[SCOORD_W-1:FRAC_W]};
            base_y_reg   <= {s_sample_y[SCOORD_W-1], s_sample_y[SCOORD_W-1:FRAC_W]};
            base_z_reg   <= {s_sample_z[SCOORD_W-1], s_sample_z[SCOORD_W-1:FRAC_W]};
            frac_x_reg   <= s_sample_x[FRAC_W-1:0];
            frac_y_reg   <= s_sample_y[FRAC_W-1:0];
            frac_z_reg   <= s_sample_z[FRAC_W-1:0];
        end
    end

    // corner coordinate into the address unit
    always_comb begin
        req.valid    = issue;
        req.is_write = is_write_reg;
        if (is_write_reg) begin
            req.x = COORD_W'(wr_x_reg);
            req.y = COORD_W'(wr_y_reg);
            req.z = COORD_W'(wr_z_reg);
        end else begin
            req.x = base_x_reg + COORD_W'(cnt_reg[0]);
            req.y = base_y_reg + COORD_W'(cnt_reg[1]);
            req.z = base_z_reg + COORD_W'(cnt_reg[2]);
        end
    end

    tvts_addr #(
        .TILE_DIM           (TILE_DIM),
        .MAX_TILES_PER_AXIS (MAX_TILES_PER_AXIS)
    ) u_addr (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .req     (req),
        .rsp     (rsp),
        .addr    (unit_addr)
    );

    // corner weight: fraction for the upper neighbor, 256 - fraction for the lower
    assign wx = cnt_reg[0] ? WAXIS_W'(frac_x_reg) : UNIT_WEIGHT - WAXIS_W'(frac_x_reg);
    assign wy = cnt_reg[1] ? WAXIS_W'(frac_y_reg) : UNIT_WEIGHT - WAXIS_W'(frac_y_reg);
    assign wz = cnt_reg[2] ? WAXIS_W'(frac_z_reg) : UNIT_WEIGHT - WAXIS_W'(frac_z_reg);

    assign wxy_full = 18'(wx) * 18'(wy);
    assign w_full   = 26'(wxy_a_reg) * 26'(wz_a_reg);

    always_ff @(posedge aclk) begin
        wxy_a_reg <= wxy_full[WPAIR_W-1:0];
        wz_a_reg  <= wz;
        w_b_reg   <= w_full[WEIGHT_W-1:0];
        w_r_reg   <= w_b_reg;
    end

    // voxel memory: clear pass and write items share the write port
    assign mem_we    = clr_we || (rsp.valid && rsp.is_write && rsp.hit);
    assign mem_waddr = clr_we ? clr_addr_reg : unit_addr;
    assign mem_wdata = clr_we ? '0 : wr_value_reg;
    assign mem_re    = rsp.valid && !rsp.is_write;

    always_ff @(posedge aclk) begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            rd_data_reg <= mem[unit_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_valid_reg   <= 1'b0;
            prod_valid_reg <= 1'b0;
        end else begin
            rd_valid_reg   <= mem_re;
            prod_valid_reg <= rd_valid_reg;
        end
        rd_hit_reg <= rsp.hit;
    end

    // out-of-range neighbors contribute 0
    assign rd_voxel  = rd_hit_reg ? rd_data_reg : '0;
    assign prod_full = 41'(rd_voxel) * 41'(w_r_reg);

    always_ff @(posedge aclk) begin
        prod_reg <= prod_full[ACC_W-1:0];
        if (s_accept)
            acc_reg <= '0;
        else if (prod_valid_reg)
            acc_reg <= acc_reg + prod_reg;
    end

    // result register: blend scaled by 2^24, keep 8 fraction bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (out_load)
            m_sample_value_reg <= acc_reg[ACC_W-1:ACC_W-RESULT_W];
    end

    assign m_valid        = m_valid_reg;
    assign m_sample_value = m_sample_value_reg;

    a_one_port_op: assert property (@(posedge aclk) disable iff (!aresetn)
        !(mem_we && mem_re))
        else $error("voxel memory read and write in the same cycle");

    a_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> (!m_valid_reg || m_ready))
        else $error("result overwrites a word not yet taken");

    a_accept_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> (pipe_empty && !clr_we))
        else $error("input taken while pipeline busy or memory clearing");

endmodule

// ----- test/tiled_volume_trilinear_sampler_tb.sv -----
module tiled_volume_trilinear_sampler_tb;

    // geometry and field widths, all from the package
    localparam int TILE      = tvts_pkg::TILE_DIM_DEF;
    localparam int MAX_TILES = tvts_pkg::MAX_TILES_DEF;
    localparam int SPAN      = TILE * MAX_TILES;
    localparam int DEPTH     = SPAN * SPAN * SPAN;
    localparam int CW        = tvts_pkg::CFG_W;
    localparam int WCW       = tvts_pkg::WCOORD_W;
    localparam int VW        = tvts_pkg::VOXEL_W;
    localparam int SCW       = tvts_pkg::SCOORD_W;
    localparam int RW        = tvts_pkg::RESULT_W;

    // action codes of an input word
    localparam logic ACT_WRITE  = tvts_pkg::ACT_WRITE;
    localparam logic ACT_SAMPLE = tvts_pkg::ACT_SAMPLE;

    // quiet cycles after the last result
    localparam int SETTLE_CYCLES = 32;
    localparam int REPORT_MAX    = 10;

    typedef struct {
        logic                  action;
        logic [WCW-1:0]        wx;
        logic [WCW-1:0]        wy;
        logic [WCW-1:0]        wz;
        logic [VW-1:0]         wv;
        logic signed [SCW-1:0] sx;
        logic signed [SCW-1:0] sy;
        logic signed [SCW-1:0] sz;
    } voxel_op_t;

    logic                        aclk          = 1'b0;
    logic                        aresetn       = 1'b0;
    logic                        cfg_wr_en     = 1'b0;
    logic [tvts_pkg::CFG_IDX_W-1:0] cfg_index  = '0;
    logic [CW-1:0]               cfg_wdata     = '0;
    logic                        s_valid       = 1'b0;
    logic                        s_ready;
    logic                        s_action      = ACT_WRITE;
    logic [WCW-1:0]              s_write_x     = '0;
    logic [WCW-1:0]              s_write_y     = '0;
    logic [WCW-1:0]              s_write_z     = '0;
    logic [VW-1:0]               s_write_value = '0;
    logic signed [SCW-1:0]       s_sample_x    = '0;
    logic signed [SCW-1:0]       s_sample_y    = '0;
    logic signed [SCW-1:0]       s_sample_z    = '0;
    logic                        m_valid;
    logic                        m_ready       = 1'b0;
    logic [RW-1:0]               m_sample_value;

    tiled_volume_trilinear_sampler u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_action       (s_action),
        .s_write_x      (s_write_x),
        .s_write_y      (s_write_y),
        .s_write_z      (s_write_z),
        .s_write_value  (s_write_value),
        .s_sample_x     (s_sample_x),
        .s_sample_y     (s_sample_y),
        .s_sample_z     (s_sample_z),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_sample_value (m_sample_value)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // words waiting to be driven, blends waiting to come out
    voxel_op_t     pending_ops[$];
    logic [RW-1:0] expected_blends[$];

    // shadow of the block: voxel memory and tile counts
    logic [VW-1:0] voxel_mem [0:DEPTH-1];
    logic [CW-1:0] tiles_wide_q;
    logic [CW-1:0] tiles_high_q;
    logic [CW-1:0] tiles_deep_q;

    int   fail_count = 0;
    int   idle_pct   = 6;   // chance in a hundred that a side idles this cycle
    logic s_fire     = 1'b0; // input word accepted at the last rising edge

    // counts above the maximum saturate
    function automatic int tiles_used(logic [CW-1:0] n);
        return (int'(n) > MAX_TILES) ? MAX_TILES : int'(n);
    endfunction

    // tile-major voxel address, -1 when negative or beyond the tiles in use
    function automatic int voxel_index(int x, int y, int z);
        int w, h, d, tx, ty, tz, a;
        w = tiles_used(tiles_wide_q);
        h = tiles_used(tiles_high_q);
        d = tiles_used(tiles_deep_q);
        if (x < 0 || y < 0 || z < 0)
            return -1;
        tx = x / TILE;
        ty = y / TILE;
        tz = z / TILE;
        if (tx >= w || ty >= h || tz >= d)
            return -1;
        a = (tz * w * h + ty * w + tx) * TILE * TILE * TILE
          + (z % TILE) * TILE * TILE + (y % TILE) * TILE + (x % TILE);
        return (a < DEPTH) ? a : -1;
    endfunction

    // exact trilinear blend of the eight neighbors, truncated to 8 fraction bits
    function automatic logic [RW-1:0] blend_at(logic signed [SCW-1:0] px,
                                               logic signed [SCW-1:0] py,
                                               logic signed [SCW-1:0] pz);
        int bx, by, bz, fx, fy, fz, dx, dy, dz, a;
        longint unsigned acc, wgt, val;
        bx = int'(px) >>> 8;
        by = int'(py) >>> 8;
        bz = int'(pz) >>> 8;
        fx = int'(px[7:0]);
        fy = int'(py[7:0]);
        fz = int'(pz[7:0]);
        acc = 0;
        for (int c = 0; c < 8; c++) begin
            dx  = c & 1;
            dy  = (c >> 1) & 1;
            dz  = (c >> 2) & 1;
            wgt = (dx ? fx : 256 - fx) * (dy ? fy : 256 - fy) * (dz ? fz : 256 - fz);
            a   = voxel_index(bx + dx, by + dy, bz + dz);
            val = (a < 0) ? 0 : voxel_mem[a];
            acc += val * wgt;
        end
        return RW'(acc >> 16);
    endfunction

    // Monitor: everything is sampled at the rising edge. Accepted input words
    // update the shadow or queue a blend; accepted result words are checked.
    always @(posedge aclk) begin : monitor
        int            a;
        logic [RW-1:0] want;
        if (!aresetn) begin
            s_fire <= 1'b0;
            tiles_wide_q = 3'd4;
            tiles_high_q = 3'd4;
            tiles_deep_q = 3'd4;
            foreach (voxel_mem[i])
                voxel_mem[i] = '0;
        end else begin
            s_fire <= s_valid && s_ready;
            if (cfg_wr_en) begin
                case (cfg_index)
                    tvts_pkg::REG_TILES_WIDE: tiles_wide_q = cfg_wdata;
                    tvts_pkg::REG_TILES_HIGH: tiles_high_q = cfg_wdata;
                    tvts_pkg::REG_TILES_DEEP: tiles_deep_q = cfg_wdata;
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                if (s_action == ACT_WRITE) begin
                    // writes outside the tiles in use are dropped
                    a = voxel_index(int'(s_write_x), int'(s_write_y), int'(s_write_z));
                    if (a >= 0)
                        voxel_mem[a] = s_write_value;
                end else begin
                    expected_blends.push_back(blend_at(s_sample_x, s_sample_y, s_sample_z));
                end
            end
            if (m_valid && m_ready) begin
                if (expected_blends.size() == 0) begin
                    fail_count++;
                    if (fail_count <= REPORT_MAX)
                        $display("unexpected result word: sample_value %h", m_sample_value);
                end else begin
                    want = expected_blends.pop_front();
                    if (m_sample_value !== want) begin
                        fail_count++;
                        if (fail_count <= REPORT_MAX)
                            $display("sample_value mismatch: expected %h, got %h",
                                     want, m_sample_value);
                    end
                end
            end
        end
    end

    // Driver: changes inputs at the falling edge. A word stays up until the
    // monitor saw it accepted; a new one may follow with no gap.
    always @(negedge aclk) begin : driver
        voxel_op_t op;
        if (!(s_valid && !s_fire)) begin
            if (pending_ops.size() != 0 && $urandom_range(99) >= idle_pct) begin
                op = pending_ops.pop_front();
                s_valid       <= 1'b1;
                s_action      <= op.action;
                s_write_x     <= op.wx;
                s_write_y     <= op.wy;
                s_write_z     <= op.wz;
                s_write_value <= op.wv;
                s_sample_x    <= op.sx;
                s_sample_y    <= op.sy;
                s_sample_z    <= op.sz;
            end else begin
                s_valid <= 1'b0;
            end
        end
        m_ready <= ($urandom_range(99) >= idle_pct);
    end

    // unused fields of a word still carry random bits
    task automatic push_write(input logic [WCW-1:0] x, input logic [WCW-1:0] y,
                              input logic [WCW-1:0] z, input logic [VW-1:0] v);
        voxel_op_t op;
        op.action = ACT_WRITE;
        op.wx = x;
        op.wy = y;
        op.wz = z;
        op.wv = v;
        op.sx = SCW'($urandom);
        op.sy = SCW'($urandom);
        op.sz = SCW'($urandom);
        pending_ops.push_back(op);
    endtask

    task automatic push_sample(input logic signed [SCW-1:0] x,
                               input logic signed [SCW-1:0] y,
                               input logic signed [SCW-1:0] z);
        voxel_op_t op;
        op.action = ACT_SAMPLE;
        op.wx = WCW'($urandom);
        op.wy = WCW'($urandom);
        op.wz = WCW'($urandom);
        op.wv = VW'($urandom);
        op.sx = x;
        op.sy = y;
        op.sz = z;
        pending_ops.push_back(op);
    endtask

    // back-to-back register writes, one per cycle
    task automatic program_tiles(input logic [CW-1:0] w, input logic [CW-1:0] h,
                                 input logic [CW-1:0] d);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= tvts_pkg::REG_TILES_WIDE;
        cfg_wdata <= w;
        @(negedge aclk);
        cfg_index <= tvts_pkg::REG_TILES_HIGH;
        cfg_wdata <= h;
        @(negedge aclk);
        cfg_index <= tvts_pkg::REG_TILES_DEEP;
        cfg_wdata <= d;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // sender holds off until every word is in and every blend is out
    task automatic drain_and_settle();
        do
            @(posedge aclk);
        while (pending_ops.size() != 0 || s_valid || expected_blends.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Mostly a cube of eight corner writes followed by samples inside it;
    // the rest is full-range noise. Bases run one past the tiles in use on
    // both ends, so negative and out-of-tile neighbors come up often.
    task automatic random_traffic(input int n, input int tw, input int th, input int td);
        int made, bx, by, bz, ex, ey, ez, cx, cy, cz;
        logic [VW-1:0] v;
        ex = ((tw > MAX_TILES) ? MAX_TILES : tw) * TILE;
        ey = ((th > MAX_TILES) ? MAX_TILES : th) * TILE;
        ez = ((td > MAX_TILES) ? MAX_TILES : td) * TILE;
        made = 0;
        while (made < n) begin
            if ($urandom_range(99) < 20) begin
                if ($urandom_range(1))
                    push_write(WCW'($urandom), WCW'($urandom), WCW'($urandom), VW'($urandom));
                else
                    push_sample(SCW'($urandom), SCW'($urandom), SCW'($urandom));
                made++;
            end else begin
                bx = int'($urandom_range(ex + 1)) - 1;
                by = int'($urandom_range(ey + 1)) - 1;
                bz = int'($urandom_range(ez + 1)) - 1;
                for (int c = 0; c < 8; c++) begin
                    cx = bx + (c & 1);
                    cy = by + ((c >> 1) & 1);
                    cz = bz + ((c >> 2) & 1);
                    v  = ($urandom_range(9) == 0) ? 16'hFFFF : VW'($urandom);
                    if (cx >= 0 && cx < SPAN && cy >= 0 && cy < SPAN && cz >= 0 && cz < SPAN) begin
                        push_write(WCW'(cx), WCW'(cy), WCW'(cz), v);
                        made++;
                    end
                end
                repeat ($urandom_range(1, 3)) begin
                    push_sample(SCW'(bx * 256 + int'($urandom_range(255))),
                                SCW'(by * 256 + int'($urandom_range(255))),
                                SCW'(bz * 256 + int'($urandom_range(255))));
                    made++;
                end
            end
        end
    endtask

    // Run: reset, then phases of tile settings. Each phase drains fully
    // before the next register write, so config only changes while idle.
    initial begin : stimulus
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // full volume; the block clears its memory first with s_ready low
        program_tiles(3'd4, 3'd4, 3'd4);

        // directed: empty read, corner and far-corner voxels, extreme values
        push_sample(17'sd0, 17'sd0, 17'sd0);
        push_write(5'd0, 5'd0, 5'd0, 16'hFFFF);
        push_write(5'd1, 5'd0, 5'd0, 16'h1234);
        push_write(5'd0, 5'd1, 5'd0, 16'h0000);
        push_write(5'd1, 5'd1, 5'd1, 16'h8000);
        push_write(5'd0, 5'd0, 5'd1, 16'h00FF);
        push_write(5'd31, 5'd31, 5'd31, 16'hFFFF);
        push_write(5'd31, 5'd0, 5'd31, 16'hABCD);
        push_write(5'd8, 5'd7, 5'd15, 16'h5A5A);   // crosses tile lines
        push_sample(17'sd0, 17'sd0, 17'sd0);       // exactly on a voxel
        push_sample(17'sd128, 17'sd128, 17'sd128);
        push_sample(17'sd255, 17'sd255, 17'sd255); // largest fraction
        push_sample(17'sd127, 17'sd0, 17'sd64);
        push_sample(-17'sd1, -17'sd1, -17'sd1);    // lower neighbors negative
        push_sample(-17'sd128, 17'sd0, 17'sd0);
        push_sample(-17'sd65536, -17'sd65536, -17'sd65536);
        push_sample(17'sd65535, 17'sd65535, 17'sd65535);
        push_sample(17'sd7936, 17'sd7936, 17'sd7936);  // last voxel, upper side outside
        push_sample(17'sd8064, 17'sd7936, 17'sd8064);
        push_sample(17'sd7936, 17'sd0, 17'sd7936);
        push_sample(17'sd2048, 17'sd1920, 17'sd3840);
        random_traffic(130, 4, 4, 4);
        drain_and_settle();

        // narrow volume, no idling on either side for the whole phase
        idle_pct = 0;
        program_tiles(3'd1, 3'd2, 3'd3);
        random_traffic(100, 1, 2, 3);
        drain_and_settle();
        idle_pct = 6;

        // counts above the maximum saturate, same map as the full volume
        program_tiles(3'd7, 3'd7, 3'd7);
        random_traffic(100, 7, 7, 7);
        drain_and_settle();

        // a zero count on one axis: reads are 0, writes are dropped
        program_tiles(3'd0, 3'd7, 3'd1);
        random_traffic(50, 0, 7, 1);
        drain_and_settle();

        program_tiles(3'd5, 3'd0, 3'd2);
        random_traffic(50, 5, 0, 2);
        drain_and_settle();

        program_tiles(3'd2, 3'd6, 3'd0);
        random_traffic(50, 2, 6, 0);
        drain_and_settle();

        // back to the full volume over whatever the store holds now
        program_tiles(3'd4, 3'd4, 3'd4);
        random_traffic(130, 4, 4, 4);
        drain_and_settle();

        if (fail_count == 0 && expected_blends.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // hang guard, far beyond the memory clear plus the slowest traffic
    initial begin : watchdog
        #2000000;
        $display("Some tests failed");
        $finish;
    end

endmodule
